// ===== hdl/cht_pkg.sv =====
package cht_pkg;

  localparam int unsigned BucketsDefault    = 16;
  localparam int unsigned ChainDepthDefault = 8;

  localparam int unsigned KeyW   = 31;
  localparam int unsigned PayW   = 32;
  localparam int unsigned CostW  = 4;
  localparam int unsigned CountW = 5;

  localparam logic [CountW-1:0] CountReset = 5'd10;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic            found;
    logic [PayW-1:0] read_payload;
    logic [CostW-1:0] cost;
    status_e         status;
  } result_t;

endpackage

// ===== hdl/chained_hash_table.sv =====
// On insert, the bucket remainder is computed one key bit a cycle, and the chain
// length is then fetched before the result is valid.
// Search and delete add a read and a compare per entry compared; delete also adds a read and a write per entry moved.
// One word at a time: a new word is accepted only once the previous result has been taken at the output.
// Reset: asynchronous active low; clears chain lengths and sets bucket count to 10.
// Stored keys and payloads are not cleared.
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS     = BucketsDefault,
  parameter int unsigned CHAIN_DEPTH = ChainDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [71:0]       s_axis_tdata,  // op[1:0], key[32:2], payload[64:33], zero[71:65]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata   // found[0] read_payload[32:1] cost[36:33] status[38:37]
);

  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned PW    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int unsigned LW    = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned AW    = BW + PW;
  localparam int unsigned MaxB  = (BUCKETS < 31) ? BUCKETS : 31;
  localparam int unsigned Slots = BUCKETS << PW;

  localparam logic [2:0] S_IDLE = 3'd0, S_MOD = 3'd1, S_LEN = 3'd2, S_RD = 3'd3,
                         S_CMP = 3'd4, S_SHR = 3'd5, S_SHW = 3'd6, S_OUT = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] divisor;
  logic              mod_start, mod_done;
  logic [CountW-1:0] rem;

  op_e               op_q;
  logic [KeyW-1:0]   key_q;
  logic [PayW-1:0]   pay_q;
  logic [BW-1:0]     bkt_q;
  logic [LW-1:0]     len_q;
  logic [LW-1:0]     pos_q;
  result_t           res_q;

  logic [LW-1:0]     len_mem [BUCKETS];
  logic [KeyW-1:0]   key_mem [Slots];
  logic [PayW-1:0]   pay_mem [Slots];
  logic [KeyW-1:0]   rd_key_q;
  logic [PayW-1:0]   rd_pay_q;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [KeyW-1:0]   wkey;
  logic [PayW-1:0]   wpay;
  logic              len_we;
  logic [LW-1:0]     len_wdata;

  always_comb begin
    divisor = count_q;
    if (count_q == '0) divisor = CountW'(1);
    if (count_q > CountW'(MaxB)) divisor = CountW'(MaxB);
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign mod_start     = s_axis_tvalid && s_axis_tready;

  cht_mod u_mod (
    .clk_i, .rst_ni,
    .start_i  (mod_start),
    .key_i    (s_axis_tdata[32:2]),
    .divisor_i(divisor),
    .done_o   (mod_done),
    .rem_o    (rem)
  );

  function automatic logic [AW-1:0] addr(logic [BW-1:0] b, logic [LW-1:0] p);
    return {b, p[PW-1:0]};
  endfunction

  always_comb begin
    state_d   = state_q;
    we        = 1'b0;
    waddr     = addr(bkt_q, len_q);
    wkey      = key_q;
    wpay      = pay_q;
    raddr     = addr(bkt_q, pos_q);
    len_we    = 1'b0;
    len_wdata = len_q;
    case (state_q)
      S_IDLE: if (mod_start) state_d = S_MOD;
      S_MOD:  if (mod_done) state_d = S_LEN;
      S_LEN: begin
        if (op_q == OP_INSERT) begin
          if (len_q < LW'(CHAIN_DEPTH)) begin
            we        = 1'b1;
            len_we    = 1'b1;
            len_wdata = len_q + 1'b1;
          end
          state_d = S_OUT;
        end else if (op_q == OP_NONE || len_q == '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD:  state_d = S_CMP;
      S_CMP: begin
        if (rd_key_q == key_q) begin
          state_d = (op_q == OP_DELETE) ? S_SHR : S_OUT;
          if (op_q == OP_DELETE) begin
            len_we    = 1'b1;
            len_wdata = len_q - 1'b1;
          end
        end else if (pos_q + 1'b1 >= len_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_RD;
        end
      end
      S_SHR: begin
        raddr   = addr(bkt_q, pos_q + 1'b1);
        state_d = (pos_q + 1'b1 >= len_q) ? S_OUT : S_SHW;
      end
      S_SHW: begin
        we      = 1'b1;
        waddr   = addr(bkt_q, pos_q);
        wkey    = rd_key_q;
        wpay    = rd_pay_q;
        state_d = S_SHR;
      end
      S_OUT: if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      pay_mem[waddr] <= wpay;
    end
    rd_key_q <= key_mem[raddr];
    rd_pay_q <= pay_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUCKETS; i++) len_mem[i] <= '0;
    end else if (len_we) begin
      len_mem[bkt_q] <= len_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= CountReset;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q  <= op_e'(s_axis_tdata[1:0]);
        key_q <= s_axis_tdata[32:2];
        pay_q <= s_axis_tdata[64:33];
        pos_q <= '0;
        res_q <= '0;
      end
      S_MOD: begin
        bkt_q <= BW'(rem);
        len_q <= len_mem[BW'(rem)];
      end
      S_LEN: begin
        if (op_q == OP_INSERT && len_q >= LW'(CHAIN_DEPTH)) res_q.status <= ST_FULL;
        if ((op_q == OP_DELETE || op_q == OP_SEARCH) && len_q == '0) begin
          res_q.status <= ST_NOTFOUND;
        end
      end
      S_CMP: begin
        if (rd_key_q == key_q) begin
          res_q.found <= 1'b1;
          res_q.cost  <= CostW'(pos_q + 1'b1);
          if (op_q == OP_SEARCH) res_q.read_payload <= rd_pay_q;
        end else if (pos_q + 1'b1 >= len_q) begin
          res_q.status <= ST_NOTFOUND;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      S_SHW: pos_q <= pos_q + 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {1'b0, res_q.status, res_q.cost, res_q.read_payload, res_q.found};

endmodule

// ===== hdl/cht_mod.sv =====
module cht_mod
  import cht_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [CountW-1:0] divisor_i,
  output logic              done_o,
  output logic [CountW-1:0] rem_o
);

  localparam int unsigned StepW = $clog2(KeyW + 1);

  logic              busy_q, busy_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [KeyW-1:0]   num_q, num_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    done_o = 1'b0;
    trial  = {rem_q, num_q[KeyW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = key_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = CountW'((trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial);
      num_d = {num_q[KeyW-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == StepW'(KeyW - 1)) begin
        busy_d = 1'b0;
      end
    end else begin
      done_o = 1'b0;
    end
    if (!busy_q && !start_i && step_q == StepW'(KeyW)) begin
      done_o = 1'b1;
      step_d = '0;
    end
  end

  assign rem_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

endmodule

// ===== sim/chained_hash_table_tb.sv =====
module chained_hash_table_tb;
  import cht_pkg::*;

  localparam int unsigned NBkt   = 16;
  localparam int unsigned NDepth = 8;

  typedef struct packed {
    logic [PayW-1:0] payload;
    logic [KeyW-1:0] key;
    op_e             op;
  } table_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [71:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;

  chained_hash_table u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  table_req_t      pending_q[$];
  result_t         expected_q[$];
  logic [KeyW-1:0] key_mem[NBkt][NDepth];
  logic [PayW-1:0] pay_mem[NBkt][NDepth];
  int unsigned     chain_len[NBkt];
  logic [CountW-1:0] bucket_reg = CountReset;
  int unsigned     mismatches = 0;
  int unsigned     send_wait = 0;
  int unsigned     recv_wait = 0;

  function automatic result_t apply_op(table_req_t r);
    result_t     res;
    int unsigned n;
    int unsigned b;
    int unsigned pos;
    res = '0;
    res.status = ST_DONE;
    n = bucket_reg;
    if (n == 0) n = 1;
    if (n > NBkt) n = NBkt;
    b = r.key % n;
    if (r.op == OP_INSERT) begin
      if (chain_len[b] >= NDepth) begin
        res.status = ST_FULL;
      end else begin
        key_mem[b][chain_len[b]] = r.key;
        pay_mem[b][chain_len[b]] = r.payload;
        chain_len[b]++;
      end
    end else if (r.op == OP_DELETE || r.op == OP_SEARCH) begin
      pos = NDepth;
      for (int i = chain_len[b] - 1; i >= 0; i--)
        if (key_mem[b][i] == r.key) pos = i;
      if (pos == NDepth) begin
        res.status = ST_NOTFOUND;
      end else begin
        res.found = 1'b1;
        res.cost = CostW'(pos + 1);
        if (r.op == OP_SEARCH) begin
          res.read_payload = pay_mem[b][pos];
        end else begin
          for (int i = pos; i + 1 < chain_len[b]; i++) begin
            key_mem[b][i] = key_mem[b][i + 1];
            pay_mem[b][i] = pay_mem[b][i + 1];
          end
          chain_len[b]--;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_q = {expected_q, apply_op(table_req_t'(s_axis_tdata[64:0]))};
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (send_wait > 0) begin
        s_axis_tvalid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, pending_q.pop_front()};
        send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[36:33], m_axis_tdata[38:37]};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got.found !== want.found || got.read_payload !== want.read_payload ||
            got.cost !== want.cost || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected f=%b p=%h c=%0d s=%0d got f=%b p=%h c=%0d s=%0d",
                     want.found, want.read_payload, want.cost, want.status,
                     got.found, got.read_payload, got.cost, got.status);
        end
      end
      recv_wait <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic add_req(op_e op, logic [KeyW-1:0] key, logic [PayW-1:0] pay);
    table_req_t r;
    r.op = op;
    r.key = key;
    r.payload = pay;
    pending_q = {pending_q, r};
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_buckets(logic [CountW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bucket_reg = v;
  endtask

  task automatic random_phase(int unsigned count, int unsigned key_span);
    logic [KeyW-1:0] k;
    int unsigned     sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 2) k = KeyW'($urandom);
      else k = KeyW'($urandom_range(0, key_span));
      if (sel == 19) add_req(OP_NONE, k, $urandom);
      else if (sel < 9) add_req(OP_INSERT, k, $urandom);
      else if (sel < 13) add_req(OP_DELETE, k, $urandom);
      else add_req(OP_SEARCH, k, $urandom);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_req(OP_SEARCH, 31'd5, 32'hFFFF_FFFF);
    add_req(OP_DELETE, 31'd5, 32'h0);
    add_req(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 31'd0, 32'h0);
    add_req(OP_SEARCH, 31'h7FFF_FFFF, 32'h0);
    for (int i = 0; i < 9; i++) add_req(OP_INSERT, KeyW'(3 + 10 * i), PayW'(32'hA000_0000 + i));
    add_req(OP_INSERT, 31'd13, 32'h1234_5678);
    add_req(OP_SEARCH, 31'd73, 32'h0);
    add_req(OP_DELETE, 31'd33, 32'h0);
    add_req(OP_SEARCH, 31'd43, 32'h0);
    add_req(OP_DELETE, 31'd3, 32'h0);
    add_req(OP_NONE, 31'd0, 32'hFFFF_FFFF);
    add_req(OP_SEARCH, 31'd0, 32'h0);
    add_req(OP_DELETE, 31'h7FFF_FFFF, 32'h0);
    wait_idle();

    set_buckets(5'd0);
    random_phase(200, 40);
    wait_idle();
    set_buckets(5'd16);
    random_phase(350, 200);
    wait_idle();
    set_buckets(5'd31);
    random_phase(300, 200);
    wait_idle();
    set_buckets(5'd7);
    random_phase(350, 100);
    wait_idle();
    set_buckets(5'd1);
    random_phase(150, 30);
    wait_idle();
    set_buckets(5'd12);
    random_phase(200, 120);
    wait_idle();

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
